>>> sv/qslerp_pkg.sv
// qslerp_pkg: shared constants and the cordic angle table for quaternion_slerp
// no dependencies; imported by the cordic unit and the top level
package qslerp_pkg;

    localparam int ONE_Q14      = 16384;
    localparam int CORDIC_STEPS = 16;
    // cordic datapath width and angle width (radians, q.16)
    localparam int CW           = 34;
    localparam int ZW           = 19;
    // gain-corrected 1.0 in q.30
    localparam logic signed [CW-1:0] CORDIC_ONE = 34'sd652032874;
    localparam logic [14:0] THR_RESET = 15'd16383;

    // atan(2^-i) in q.16 radians
    function automatic logic signed [ZW-1:0] arc_angle(input int idx);
        logic signed [ZW-1:0] a;
        unique case (idx)
            0:       a = 19'sd51472;
            1:       a = 19'sd30386;
            2:       a = 19'sd16055;
            3:       a = 19'sd8150;
            4:       a = 19'sd4091;
            5:       a = 19'sd2047;
            6:       a = 19'sd1024;
            7:       a = 19'sd512;
            8:       a = 19'sd256;
            9:       a = 19'sd128;
            10:      a = 19'sd64;
            11:      a = 19'sd32;
            12:      a = 19'sd16;
            13:      a = 19'sd8;
            14:      a = 19'sd4;
            15:      a = 19'sd2;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

>>> sv/qslerp_delay.sv
// qslerp_delay: fixed-depth shift line that keeps side data aligned with the datapath
// no dependencies
module qslerp_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         clk,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] pipe_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        pipe_reg[0] <= din;
        for (int k = 1; k < DEPTH; k++)
        begin
            pipe_reg[k] <= pipe_reg[k-1];
        end
    end

    assign dout = pipe_reg[DEPTH-1];

endmodule

>>> sv/qslerp_sqrt.sv
// qslerp_sqrt: pipelined floor square root, one result bit per stage
// no dependencies
module qslerp_sqrt #(
    parameter int N = 15
) (
    input  logic           clk,
    input  logic [2*N-1:0] rad,
    output logic [N-1:0]   root
);

    logic [N+1:0]   rem_reg  [N];
    logic [N-1:0]   root_reg [N];
    logic [2*N-1:0] rad_reg  [N];

    for (genvar k = 0; k < N; k++)
    begin : g_step
        logic [N+1:0]   rem_in, remx, trial, rem_next;
        logic [N-1:0]   root_in, root_next;
        logic [2*N-1:0] rad_in, rad_next;
        logic           ge;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
        end

        always_comb
        begin
            remx      = {rem_in[N-1:0], rad_in[2*N-1 -: 2]};
            trial     = {root_in, 2'b01};
            ge        = (remx >= trial);
            rem_next  = ge ? (remx - trial) : remx;
            root_next = {root_in[N-2:0], ge};
            rad_next  = {rad_in[2*N-3:0], 2'b00};
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_next;
            root_reg[k] <= root_next;
            rad_reg[k]  <= rad_next;
        end
    end

    assign root = root_reg[N-1];

endmodule

>>> sv/qslerp_cordic.sv
// qslerp_cordic: 16-stage pipelined cordic, vectoring (angle) or rotation (sine) mode
// depends on qslerp_pkg for widths, step count and the angle table
module qslerp_cordic import qslerp_pkg::*; #(
    parameter bit VECTOR = 1'b0
) (
    input  logic                 clk,
    input  logic signed [CW-1:0] x_in,
    input  logic signed [CW-1:0] y_in,
    input  logic signed [ZW-1:0] z_in,
    output logic signed [CW-1:0] y_out,
    output logic signed [ZW-1:0] z_out
);

    logic signed [CW-1:0] x_reg [CORDIC_STEPS];
    logic signed [CW-1:0] y_reg [CORDIC_STEPS];
    logic signed [ZW-1:0] z_reg [CORDIC_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_stage
        logic signed [CW-1:0] x_i, y_i, x_next, y_next;
        logic signed [ZW-1:0] z_i, z_next, arc;
        logic                 up;

        if (i == 0)
        begin : g_first
            assign x_i = x_in;
            assign y_i = y_in;
            assign z_i = z_in;
        end
        else
        begin : g_rest
            assign x_i = x_reg[i-1];
            assign y_i = y_reg[i-1];
            assign z_i = z_reg[i-1];
        end

        assign arc = arc_angle(i);

        // vectoring drives y to zero, rotation drives z to zero
        always_comb
        begin
            up = VECTOR ? !y_i[CW-1] : z_i[ZW-1];
            if (up)
            begin
                x_next = x_i + (y_i >>> i);
                y_next = y_i - (x_i >>> i);
                z_next = z_i + arc;
            end
            else
            begin
                x_next = x_i - (y_i >>> i);
                y_next = y_i + (x_i >>> i);
                z_next = z_i - arc;
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[i] <= x_next;
            y_reg[i] <= y_next;
            z_reg[i] <= z_next;
        end
    end

    assign y_out = y_reg[CORDIC_STEPS-1];
    assign z_out = z_reg[CORDIC_STEPS-1];

endmodule

>>> sv/qslerp_div.sv
// qslerp_div: pipelined rounded unsigned divider, quotient limited to QMAX
// no dependencies
module qslerp_div #(
    parameter int NW   = 45,
    parameter int DW   = 31,
    parameter int QB   = 16,
    parameter int QMAX = 32768
) (
    input  logic          clk,
    input  logic [NW-1:0] n,
    input  logic [DW-1:0] d,
    output logic [QB-1:0] q
);

    localparam int RW = ((NW + 1 > DW + QB) ? NW + 1 : DW + QB) + 1;

    logic [RW-1:0] n2_reg, rb_reg;
    logic [DW-1:0] da_reg, db_reg;
    logic          ovfb_reg;
    logic [RW-1:0] rem_reg [QB];
    logic [QB-1:0] quo_reg [QB];
    logic [DW-1:0] d_reg   [QB];
    logic          ovf_reg [QB];
    logic [QB-1:0] q_reg;
    logic [QB-1:0] q_next;
    logic [RW-1:0] n2_next;
    logic          ovf_next;

    // round half up: add half the divisor first
    assign n2_next  = RW'(n) + RW'(d >> 1);
    assign ovf_next = (n2_reg >= (RW'(da_reg) << QB));

    always_ff @(posedge clk)
    begin
        n2_reg   <= n2_next;
        da_reg   <= d;
        rb_reg   <= n2_reg;
        db_reg   <= da_reg;
        ovfb_reg <= ovf_next;
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_bit
        logic [RW-1:0] rem_in, dsh, rem_next;
        logic [QB-1:0] quo_in, quo_next;
        logic [DW-1:0] d_in;
        logic          ovf_in, ge;

        if (k == 0)
        begin : g_first
            assign rem_in = rb_reg;
            assign quo_in = '0;
            assign d_in   = db_reg;
            assign ovf_in = ovfb_reg;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign d_in   = d_reg[k-1];
            assign ovf_in = ovf_reg[k-1];
        end

        always_comb
        begin
            dsh      = RW'(d_in) << (QB - 1 - k);
            ge       = (rem_in >= dsh);
            rem_next = ge ? (rem_in - dsh) : rem_in;
            quo_next = {quo_in[QB-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= rem_next;
            quo_reg[k] <= quo_next;
            d_reg[k]   <= d_in;
            ovf_reg[k] <= ovf_in;
        end
    end

    always_comb
    begin
        if (ovf_reg[QB-1] || (quo_reg[QB-1] > QB'(QMAX)))
        begin
            q_next = QB'(QMAX);
        end
        else
        begin
            q_next = quo_reg[QB-1];
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

>>> sv/quaternion_slerp.sv
// quaternion_slerp: pipelined fixed-point quaternion slerp, q1.14 in and out
// depends on qslerp_pkg, qslerp_delay, qslerp_sqrt, qslerp_cordic, qslerp_div
//
// usage
//   a transaction enters when start is high and busy is low; busy is tied low,
//   so one transaction may enter on every clock cycle
//   each transaction yields exactly one result: out_x..out_w and linear_used
//   are valid in the single cycle where done is high, and the receiver takes
//   them at the edge that ends that cycle; the receiver cannot stall
//   throughput is one transaction per cycle
//   the pipeline is made of the two root pipelines (15 and 26 stages), the
//   angle cordic and the sine cordics (16 each), the two divider pipelines
//   (19 and 18 stages) and the stages of products, sums and rounding
//   cfg_we writes cfg_wdata into the near-one threshold; write it only while no
//   transaction is in flight
//   reset clears the valid chain (no done pulses) and loads the threshold with
//   16383; datapath registers are not reset
module quaternion_slerp import qslerp_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               cfg_we,
    input  logic [14:0]        cfg_wdata,
    input  logic signed [15:0] start_x,
    input  logic signed [15:0] start_y,
    input  logic signed [15:0] start_z,
    input  logic signed [15:0] start_w,
    input  logic signed [15:0] end_x,
    input  logic signed [15:0] end_y,
    input  logic signed [15:0] end_z,
    input  logic signed [15:0] end_w,
    input  logic signed [15:0] blend_factor,
    output logic               done,
    output logic signed [15:0] out_x,
    output logic signed [15:0] out_y,
    output logic signed [15:0] out_z,
    output logic signed [15:0] out_w,
    output logic               linear_used
);

    // pipeline timing, counted in register stages from the input stage
    localparam int ROOT_C_N  = 15;
    localparam int ROOT_M_N  = 26;
    localparam int DIVW_QB   = 16;
    localparam int DIVO_QB   = 15;
    localparam int DIVW_LAT  = DIVW_QB + 3;
    localparam int DIVO_LAT  = DIVO_QB + 3;
    localparam int ST_THETA  = 4 + ROOT_C_N + CORDIC_STEPS;     // 35
    localparam int ST_SINE   = ST_THETA + 2 + CORDIC_STEPS;     // 53
    localparam int ST_WEIGHT = ST_SINE + DIVW_LAT;              // 72
    localparam int ST_MAG    = ST_WEIGHT + 4 + ROOT_M_N;        // 102
    localparam int ST_QUOT   = ST_MAG + DIVO_LAT;               // 120
    localparam int LAT       = ST_QUOT + 1;                     // 121

    // per-transaction side data that rides along the spherical path
    typedef struct packed {
        logic [14:0]      t;
        logic [3:0][15:0] s;
        logic [3:0][16:0] ec;
    } side_t;

    typedef struct packed {
        logic             lin;
        logic [3:0][15:0] res;
    } lin_side_t;

    logic [14:0]  thr_reg;
    logic [LAT-1:0] vld_reg;

    // ---------------------------------------------------------------------
    // config register and valid chain
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
            vld_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            vld_reg <= {vld_reg[LAT-2:0], start};
        end
    end

    assign busy = 1'b0;
    assign done = vld_reg[LAT-1];

    // ---------------------------------------------------------------------
    // stage 1: capture, clamp the blend factor to 0..1
    // ---------------------------------------------------------------------
    logic signed [15:0] s1_reg [4];
    logic signed [15:0] e1_reg [4];
    logic [14:0]        t1_reg, t1_next;

    always_comb
    begin
        if (blend_factor[15])
        begin
            t1_next = '0;
        end
        else if (blend_factor > 16'sd16384)
        begin
            t1_next = 15'(ONE_Q14);
        end
        else
        begin
            t1_next = blend_factor[14:0];
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg[0] <= start_x;
        s1_reg[1] <= start_y;
        s1_reg[2] <= start_z;
        s1_reg[3] <= start_w;
        e1_reg[0] <= end_x;
        e1_reg[1] <= end_y;
        e1_reg[2] <= end_z;
        e1_reg[3] <= end_w;
        t1_reg    <= t1_next;
    end

    // ---------------------------------------------------------------------
    // stage 2: component products of the dot
    // ---------------------------------------------------------------------
    logic signed [31:0] p2_reg [4];
    logic signed [15:0] s2_reg [4];
    logic signed [15:0] e2_reg [4];
    logic [14:0]        t2_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            p2_reg[i] <= 32'(s1_reg[i]) * 32'(e1_reg[i]);
            s2_reg[i] <= s1_reg[i];
            e2_reg[i] <= e1_reg[i];
        end
        t2_reg <= t1_reg;
    end

    // ---------------------------------------------------------------------
    // stage 3: dot sum, absolute value, rounded q1.14 cosine
    // ---------------------------------------------------------------------
    logic signed [33:0] dot3;
    logic [33:0]        adot3;
    logic [18:0]        cos3_reg, cos3_next;
    logic               neg3_reg;
    logic signed [15:0] s3_reg [4];
    logic signed [15:0] e3_reg [4];
    logic [14:0]        t3_reg;

    always_comb
    begin
        dot3      = 34'(p2_reg[0]) + 34'(p2_reg[1]) + 34'(p2_reg[2]) + 34'(p2_reg[3]);
        adot3     = dot3[33] ? 34'(-dot3) : 34'(dot3);
        cos3_next = 19'((adot3 + 34'd8192) >> 14);
    end

    always_ff @(posedge clk)
    begin
        cos3_reg <= cos3_next;
        neg3_reg <= dot3[33];
        for (int i = 0; i < 4; i++)
        begin
            s3_reg[i] <= s2_reg[i];
            e3_reg[i] <= e2_reg[i];
        end
        t3_reg <= t2_reg;
    end

    // ---------------------------------------------------------------------
    // stage 4: path choice, shorter-arc end, radicand for the sine of theta
    // ---------------------------------------------------------------------
    logic               lin4_reg;
    logic [14:0]        c4_reg, c4_next;
    logic [29:0]        rad4_reg, rad4_next;
    logic signed [15:0] s4_reg  [4];
    logic signed [16:0] ec4_reg [4];
    logic [14:0]        t4_reg;

    always_comb
    begin
        c4_next   = (cos3_reg > 19'(ONE_Q14)) ? 15'(ONE_Q14) : cos3_reg[14:0];
        rad4_next = 30'd268435456 - 30'(c4_next) * 30'(c4_next);
    end

    always_ff @(posedge clk)
    begin
        lin4_reg <= (cos3_reg > {4'b0, thr_reg});
        c4_reg   <= c4_next;
        rad4_reg <= rad4_next;
        for (int i = 0; i < 4; i++)
        begin
            s4_reg[i]  <= s3_reg[i];
            ec4_reg[i] <= neg3_reg ? -17'(e3_reg[i]) : 17'(e3_reg[i]);
        end
        t4_reg <= t3_reg;
    end

    // ---------------------------------------------------------------------
    // stages 5-6: linear blend, rounded and saturated
    // ---------------------------------------------------------------------
    logic signed [31:0] la5_reg [4];
    logic signed [32:0] lb5_reg [4];
    logic               lin5_reg, lin6_reg;
    logic signed [15:0] lres6_reg  [4];
    logic signed [15:0] lres6_next [4];
    logic [14:0]        omt4;

    assign omt4 = 15'(ONE_Q14) - t4_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            la5_reg[i] <= 32'($signed({1'b0, omt4})) * 32'(s4_reg[i]);
            lb5_reg[i] <= 33'($signed({1'b0, t4_reg})) * 33'(ec4_reg[i]);
        end
        lin5_reg <= lin4_reg;
    end

    always_comb
    begin
        logic signed [33:0] v;
        logic [33:0]        m;
        logic [33:0]        r;
        logic [14:0]        rs;
        for (int i = 0; i < 4; i++)
        begin
            v  = 34'(la5_reg[i]) + 34'(lb5_reg[i]);
            m  = v[33] ? 34'(-v) : 34'(v);
            r  = (m + 34'd8192) >> 14;
            rs = (r > 34'(ONE_Q14)) ? 15'(ONE_Q14) : r[14:0];
            lres6_next[i] = v[33] ? -16'(rs) : 16'(rs);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            lres6_reg[i] <= lres6_next[i];
        end
        lin6_reg <= lin5_reg;
    end

    lin_side_t lin6_side, linq_side;

    always_comb
    begin
        lin6_side.lin = lin6_reg;
        for (int i = 0; i < 4; i++)
        begin
            lin6_side.res[i] = lres6_reg[i];
        end
    end

    qslerp_delay #(.W($bits(lin_side_t)), .DEPTH(ST_QUOT - 6)) u_lin_dly (
        .clk  (clk),
        .din  (lin6_side),
        .dout (linq_side)
    );

    // ---------------------------------------------------------------------
    // stages 5-19: sine of theta as sqrt(1 - c^2); c rides alongside
    // ---------------------------------------------------------------------
    logic [14:0] sin_c19, c19;

    qslerp_sqrt #(.N(ROOT_C_N)) u_root_c (
        .clk  (clk),
        .rad  (rad4_reg),
        .root (sin_c19)
    );

    qslerp_delay #(.W(15), .DEPTH(ROOT_C_N)) u_c_dly (
        .clk  (clk),
        .din  (c4_reg),
        .dout (c19)
    );

    // ---------------------------------------------------------------------
    // stages 20-35: theta = atan2(s, c) by vectoring cordic
    // ---------------------------------------------------------------------
    logic signed [CW-1:0] vx19, vy19, vy_unused;
    logic signed [ZW-1:0] vz35;
    logic [16:0]          theta35;

    assign vx19 = CW'({c19, 16'b0});
    assign vy19 = CW'({sin_c19, 16'b0});

    qslerp_cordic #(.VECTOR(1'b1)) u_acos (
        .clk   (clk),
        .x_in  (vx19),
        .y_in  (vy19),
        .z_in  ('0),
        .y_out (vy_unused),
        .z_out (vz35)
    );

    // negative angles from cordic overshoot are clamped at zero
    assign theta35 = vz35[ZW-1] ? '0 : vz35[16:0];

    side_t side4, side35, side72;

    always_comb
    begin
        side4.t = t4_reg;
        for (int i = 0; i < 4; i++)
        begin
            side4.s[i]  = s4_reg[i];
            side4.ec[i] = ec4_reg[i];
        end
    end

    qslerp_delay #(.W($bits(side_t)), .DEPTH(ST_THETA - 4)) u_side_a_dly (
        .clk  (clk),
        .din  (side4),
        .dout (side35)
    );

    // ---------------------------------------------------------------------
    // stages 36-37: partial angles (1-t)*theta and t*theta
    // ---------------------------------------------------------------------
    logic [31:0] pa36_reg, pb36_reg;
    logic [16:0] theta36_reg, theta37_reg, ta37_reg, tb37_reg;

    always_ff @(posedge clk)
    begin
        pa36_reg    <= 32'(15'(ONE_Q14) - side35.t) * 32'(theta35);
        pb36_reg    <= 32'(side35.t) * 32'(theta35);
        theta36_reg <= theta35;
        ta37_reg    <= 17'((pa36_reg + 32'd8192) >> 14);
        tb37_reg    <= 17'((pb36_reg + 32'd8192) >> 14);
        theta37_reg <= theta36_reg;
    end

    // ---------------------------------------------------------------------
    // stages 38-53: three rotation cordics for sin(theta), sin(ta), sin(tb)
    // ---------------------------------------------------------------------
    logic signed [CW-1:0] ys_t, ys_a, ys_b;
    logic signed [ZW-1:0] zs_t, zs_a, zs_b;
    logic [30:0]          sin_t53, sin_a53, sin_b53;

    qslerp_cordic #(.VECTOR(1'b0)) u_sin_t (
        .clk   (clk),
        .x_in  (CORDIC_ONE),
        .y_in  ('0),
        .z_in  (ZW'(theta37_reg)),
        .y_out (ys_t),
        .z_out (zs_t)
    );

    qslerp_cordic #(.VECTOR(1'b0)) u_sin_a (
        .clk   (clk),
        .x_in  (CORDIC_ONE),
        .y_in  ('0),
        .z_in  (ZW'(ta37_reg)),
        .y_out (ys_a),
        .z_out (zs_a)
    );

    qslerp_cordic #(.VECTOR(1'b0)) u_sin_b (
        .clk   (clk),
        .x_in  (CORDIC_ONE),
        .y_in  ('0),
        .z_in  (ZW'(tb37_reg)),
        .y_out (ys_b),
        .z_out (zs_b)
    );

    assign sin_t53 = ys_t[CW-1] ? '0 : ys_t[30:0];
    assign sin_a53 = ys_a[CW-1] ? '0 : ys_a[30:0];
    assign sin_b53 = ys_b[CW-1] ? '0 : ys_b[30:0];

    // ---------------------------------------------------------------------
    // stages 54-72: weights sin(ta)/sin(theta) and sin(tb)/sin(theta)
    // ---------------------------------------------------------------------
    logic [DIVW_QB-1:0] wq_a72, wq_b72;
    logic               stz72;

    qslerp_div #(.NW(45), .DW(31), .QB(DIVW_QB), .QMAX(2 * ONE_Q14)) u_div_wa (
        .clk (clk),
        .n   ({sin_a53, 14'b0}),
        .d   (sin_t53),
        .q   (wq_a72)
    );

    qslerp_div #(.NW(45), .DW(31), .QB(DIVW_QB), .QMAX(2 * ONE_Q14)) u_div_wb (
        .clk (clk),
        .n   ({sin_b53, 14'b0}),
        .d   (sin_t53),
        .q   (wq_b72)
    );

    // zero sine of theta falls back to the plain weights
    qslerp_delay #(.W(1), .DEPTH(DIVW_LAT)) u_stz_dly (
        .clk  (clk),
        .din  (sin_t53 == '0),
        .dout (stz72)
    );

    qslerp_delay #(.W($bits(side_t)), .DEPTH(ST_WEIGHT - ST_THETA)) u_side_b_dly (
        .clk  (clk),
        .din  (side35),
        .dout (side72)
    );

    // ---------------------------------------------------------------------
    // stages 73-76: weighted blend, q.21 components, squared magnitude
    // ---------------------------------------------------------------------
    logic [15:0]        wa72, wb72;
    logic signed [32:0] pa73_reg [4];
    logic signed [33:0] pb73_reg [4];
    logic signed [25:0] b74_reg  [4];
    logic signed [25:0] b74_next [4];
    logic signed [25:0] b75_reg  [4];
    logic signed [25:0] b76_reg  [4];
    logic signed [51:0] sq74     [4];
    logic [48:0]        bsq75_reg [4];
    logic [51:0]        mag2_reg;

    assign wa72 = stz72 ? 16'(15'(ONE_Q14) - side72.t) : wq_a72;
    assign wb72 = stz72 ? 16'(side72.t) : wq_b72;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            pa73_reg[i] <= 33'($signed({1'b0, wa72})) * 33'($signed(side72.s[i]));
            pb73_reg[i] <= 34'($signed({1'b0, wb72})) * 34'($signed(side72.ec[i]));
        end
    end

    always_comb
    begin
        logic signed [34:0] v;
        logic [34:0]        m;
        logic [34:0]        r;
        for (int i = 0; i < 4; i++)
        begin
            v = 35'(pa73_reg[i]) + 35'(pb73_reg[i]);
            m = v[34] ? 35'(-v) : 35'(v);
            r = (m + 35'd64) >> 7;
            b74_next[i] = v[34] ? -26'(r) : 26'(r);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            sq74[i] = 52'(b74_reg[i]) * 52'(b74_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            b74_reg[i]   <= b74_next[i];
            bsq75_reg[i] <= sq74[i][48:0];
            b75_reg[i]   <= b74_reg[i];
            b76_reg[i]   <= b75_reg[i];
        end
        mag2_reg <= 52'(bsq75_reg[0]) + 52'(bsq75_reg[1])
                  + 52'(bsq75_reg[2]) + 52'(bsq75_reg[3]);
    end

    // ---------------------------------------------------------------------
    // stages 77-102: magnitude by square root; components ride alongside
    // ---------------------------------------------------------------------
    logic [25:0]        mag102;
    logic [3:0][25:0]   b76_pk, b102_pk;

    qslerp_sqrt #(.N(ROOT_M_N)) u_root_m (
        .clk  (clk),
        .rad  (mag2_reg),
        .root (mag102)
    );

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            b76_pk[i] = b76_reg[i];
        end
    end

    qslerp_delay #(.W(104), .DEPTH(ROOT_M_N)) u_b_dly (
        .clk  (clk),
        .din  (b76_pk),
        .dout (b102_pk)
    );

    // ---------------------------------------------------------------------
    // stages 103-120: normalize each component by the magnitude
    // ---------------------------------------------------------------------
    logic [3:0]         bneg102, bneg120;
    logic [3:0][25:0]   babs102;
    logic [3:0][14:0]   q120;
    logic               magz120;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            bneg102[i] = b102_pk[i][25];
            babs102[i] = b102_pk[i][25] ? 26'(-b102_pk[i]) : b102_pk[i];
        end
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_norm
        qslerp_div #(.NW(40), .DW(26), .QB(DIVO_QB), .QMAX(ONE_Q14)) u_div_o (
            .clk (clk),
            .n   ({babs102[g], 14'b0}),
            .d   (mag102),
            .q   (q120[g])
        );
    end

    qslerp_delay #(.W(5), .DEPTH(DIVO_LAT)) u_sgn_dly (
        .clk  (clk),
        .din  ({mag102 == '0, bneg102}),
        .dout ({magz120, bneg120})
    );

    // ---------------------------------------------------------------------
    // stage 121: path select, identity on zero magnitude, output register
    // ---------------------------------------------------------------------
    logic signed [15:0] res_reg  [4];
    logic signed [15:0] res_next [4];
    logic               lin_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (linq_side.lin)
            begin
                res_next[i] = linq_side.res[i];
            end
            else if (magz120)
            begin
                // identity quaternion, w is the last component
                res_next[i] = (i == 3) ? 16'(ONE_Q14) : '0;
            end
            else
            begin
                res_next[i] = bneg120[i] ? -16'(q120[i]) : 16'(q120[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            res_reg[i] <= res_next[i];
        end
        lin_reg <= linq_side.lin;
    end

    assign out_x       = res_reg[0];
    assign out_y       = res_reg[1];
    assign out_z       = res_reg[2];
    assign out_w       = res_reg[3];
    assign linear_used = lin_reg;

endmodule
